FILE: hw/rtl/tff_pkg.sv
// shared constants, types and elaboration helpers for the ternary flip register file
package tff_pkg;

  localparam int DEF_NUM_REGS   = 64;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_TRIT_COUNT = 21;

  localparam int FUNC_BITS    = 1;
  localparam int INDEX_BITS   = 7;
  localparam int IDX_EXT_BITS = INDEX_BITS + 2;
  localparam int DATA_BITS    = 32;
  localparam int FLIP_BITS    = 31;
  localparam int POW_BITS     = 72;

  localparam logic [FLIP_BITS-1:0] FLIP_MAX = '1;

  localparam logic [FUNC_BITS-1:0] FUNC_READ  = 1'b0;
  localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } rf_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tu_status_t;

  function automatic logic [POW_BITS-1:0] pow3(input int unsigned n);
    logic [POW_BITS-1:0] p;
    p = POW_BITS'(1);
    for (int unsigned i = 0; i < n; i++) begin
      p = p * POW_BITS'(3);
    end
    return p;
  endfunction

  // trits needed to hold any value of the given two's complement width
  function automatic int unsigned trit_span(input int unsigned vb);
    int unsigned k;
    logic [POW_BITS-1:0] p;
    logic [POW_BITS-1:0] lim;
    k   = 0;
    p   = POW_BITS'(1);
    lim = POW_BITS'(1) << (vb - 1);
    while ((p >> 1) < lim) begin
      p = p * POW_BITS'(3);
      k++;
    end
    return k;
  endfunction

endpackage

FILE: hw/rtl/ternary_register_file_flip_count_top.sv
// top level: register file with signed indices and balanced ternary flip total
// a read transaction passes from IDLE through READ to OUT, and a new one is taken only back in IDLE
// a write to a live register passes READ, CONV and OUT (S trits cover VALUE_BITS, 21 at 32 bits)
// OUT waits while the output is stalled; writes to register zero or a bad index run like reads
// in CONV the trit comparator steps one trit position per cycle through the S trits
// synchronous active-low reset clears the flip accumulator, all store valid bits and the output valid
module ternary_register_file_flip_count_top #(
  parameter int NUM_REGS   = tff_pkg::DEF_NUM_REGS,
  parameter int VALUE_BITS = tff_pkg::DEF_VALUE_BITS,
  parameter int TRIT_COUNT = tff_pkg::DEF_TRIT_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tff_pkg::FUNC_BITS-1:0]        in_func,
  input  logic signed [tff_pkg::INDEX_BITS-1:0] in_reg_index,
  input  logic signed [tff_pkg::DATA_BITS-1:0] in_write_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tff_pkg::DATA_BITS-1:0] out_read_value,
  output logic [tff_pkg::FLIP_BITS-1:0]        out_flip_total,
  output logic                                 out_bad_index
);
  import tff_pkg::*;

  localparam int AW       = $clog2(NUM_REGS);
  localparam int LOW_IDX  = (NUM_REGS - 1) / 2;
  localparam int HIGH_IDX = NUM_REGS / 2;
  localparam int SPAN     = trit_span(VALUE_BITS);
  localparam int CMP      = (SPAN < TRIT_COUNT) ? SPAN : TRIT_COUNT;
  localparam int CW       = $clog2(CMP + 1);

  localparam logic signed [IDX_EXT_BITS-1:0] LO_S  = IDX_EXT_BITS'(-LOW_IDX);
  localparam logic signed [IDX_EXT_BITS-1:0] HI_S  = IDX_EXT_BITS'(HIGH_IDX);
  localparam logic signed [IDX_EXT_BITS-1:0] OFS_S = IDX_EXT_BITS'(LOW_IDX);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CONV = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [FLIP_BITS-1:0]   acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [FUNC_BITS-1:0]   func_r;
  logic                   bad_r, zero_r;
  logic [AW-1:0]          slot_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic [DATA_BITS-1:0]   res_read_r, res_read_nxt;
  logic [DATA_BITS-1:0]   out_read_r;
  logic [FLIP_BITS-1:0]   out_flip_r;
  logic                   out_bad_r;

  logic signed [IDX_EXT_BITS-1:0] idx_w, slot_w;
  logic                   in_bad, in_zero, in_acc;
  logic [AW-1:0]          in_slot;
  logic                   wr_ok, out_free, out_load;
  logic [FLIP_BITS:0]     sum_w;

  rf_ctl_t                rf_ctl;
  logic [AW-1:0]          rf_addr;
  logic [VALUE_BITS-1:0]  rf_rd_data;
  tu_status_t             tu_st;
  logic [CW-1:0]          tu_flips;

  assign idx_w   = IDX_EXT_BITS'(in_reg_index);
  assign in_bad  = (idx_w < LO_S) || (idx_w > HI_S);
  assign in_zero = (idx_w == '0);
  assign slot_w  = idx_w + OFS_S;
  assign in_slot = slot_w[AW-1:0];

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign wr_ok    = (func_r == FUNC_WRITE) && !bad_r && !zero_r;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == S_OUT) && out_free;

  assign rf_ctl.rd_en = in_acc;
  assign rf_ctl.wr_en = (state_r == S_READ) && wr_ok;
  assign rf_addr      = (state_r == S_IDLE) ? in_slot : slot_r;

  assign sum_w = {1'b0, acc_r} + (FLIP_BITS + 1)'(tu_flips);

  tff_regfile #(
    .NUM_REGS   (NUM_REGS),
    .VALUE_BITS (VALUE_BITS)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (rf_ctl),
    .addr    (rf_addr),
    .wr_data (val_r),
    .rd_data (rf_rd_data)
  );

  tff_trit_unit #(
    .VALUE_BITS (VALUE_BITS),
    .TRIT_COUNT (TRIT_COUNT)
  ) u_trit_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((state_r == S_READ) && wr_ok),
    .old_val (rf_rd_data),
    .new_val (val_r),
    .status  (tu_st),
    .flips   (tu_flips)
  );

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    res_read_nxt  = res_read_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        res_read_nxt = ((func_r == FUNC_READ) && !bad_r && !zero_r) ?
                       DATA_BITS'(rf_rd_data) : '0;
        state_nxt    = wr_ok ? S_CONV : S_OUT;
      end
      S_CONV: begin
        if (tu_st.done) begin
          acc_nxt   = sum_w[FLIP_BITS] ? FLIP_MAX : sum_w[FLIP_BITS-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      bad_r  <= in_bad;
      zero_r <= in_zero;
      slot_r <= in_slot;
      val_r  <= VALUE_BITS'(in_write_value);
    end
    res_read_r <= res_read_nxt;
    if (out_load) begin
      out_read_r <= res_read_r;
      out_flip_r <= acc_r;
      out_bad_r  <= bad_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_r;
  assign out_flip_total = out_flip_r;
  assign out_bad_index  = out_bad_r;

endmodule

FILE: hw/rtl/tff_regfile.sv
// register store: synchronous memory with registered read and per-entry valid bits
module tff_regfile #(
  parameter int NUM_REGS   = tff_pkg::DEF_NUM_REGS,
  parameter int VALUE_BITS = tff_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tff_pkg::rf_ctl_t              ctl,
  input  logic [$clog2(NUM_REGS)-1:0]   addr,
  input  logic [VALUE_BITS-1:0]         wr_data,
  output logic [VALUE_BITS-1:0]         rd_data
);
  import tff_pkg::*;

  logic [VALUE_BITS-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]   vld_r;
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  // entries never written read as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: hw/rtl/tff_trit_unit.sv
// balanced ternary comparator: one trit position of both values per cycle, msb first
module tff_trit_unit #(
  parameter int VALUE_BITS = tff_pkg::DEF_VALUE_BITS,
  parameter int TRIT_COUNT = tff_pkg::DEF_TRIT_COUNT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_BITS-1:0]  old_val,
  input  logic [VALUE_BITS-1:0]  new_val,
  output tff_pkg::tu_status_t    status,
  output logic [$clog2(((tff_pkg::trit_span(VALUE_BITS) < TRIT_COUNT) ?
                        tff_pkg::trit_span(VALUE_BITS) : TRIT_COUNT) + 1)-1:0] flips
);
  import tff_pkg::*;

  localparam int SPAN = trit_span(VALUE_BITS);
  localparam int CMP  = (SPAN < TRIT_COUNT) ? SPAN : TRIT_COUNT;
  localparam int CW   = $clog2(CMP + 1);
  localparam int DW   = $clog2(SPAN);
  localparam int RW   = VALUE_BITS + 2;

  logic signed [RW-1:0] pow_tbl  [SPAN];
  logic signed [RW-1:0] half_tbl [SPAN];

  for (genvar g = 0; g < SPAN; g++) begin : g_tbl
    assign pow_tbl[g]  = RW'(pow3(g));
    assign half_tbl[g] = RW'(pow3(g) >> 1);
  end

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DW-1:0]        dig_r, dig_nxt;
  logic signed [RW-1:0] old_r, old_nxt;
  logic signed [RW-1:0] new_r, new_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;

  logic signed [RW-1:0] p, h;
  logic                 o_pos, o_neg, n_pos, n_neg;
  logic                 differ, in_span;

  always_comb begin
    p       = pow_tbl[dig_r];
    h       = half_tbl[dig_r];
    o_pos   = old_r > h;
    o_neg   = old_r < -h;
    n_pos   = new_r > h;
    n_neg   = new_r < -h;
    differ  = (o_pos != n_pos) || (o_neg != n_neg);
    in_span = int'(dig_r) < TRIT_COUNT;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dig_nxt  = dig_r;
    old_nxt  = old_r;
    new_nxt  = new_r;
    cnt_nxt  = cnt_r;

    if (start) begin
      busy_nxt = 1'b1;
      dig_nxt  = DW'(SPAN - 1);
      old_nxt  = RW'(signed'(old_val));
      new_nxt  = RW'(signed'(new_val));
      cnt_nxt  = '0;
    end else if (busy_r) begin
      old_nxt = o_pos ? old_r - p : (o_neg ? old_r + p : old_r);
      new_nxt = n_pos ? new_r - p : (n_neg ? new_r + p : new_r);
      cnt_nxt = cnt_r + CW'(differ && in_span);
      dig_nxt = dig_r - DW'(1);
      if (dig_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    old_r <= old_nxt;
    new_r <= new_nxt;
    cnt_r <= cnt_nxt;
  end

  assign status = '{busy: busy_r, done: done_r};
  assign flips  = cnt_r;

endmodule

FILE: hw/rtl/tff_checker.sv
// port-level checker for the ternary flip register file, bound to the top level
module tff_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [tff_pkg::DATA_BITS-1:0] out_read_value,
  input logic [tff_pkg::FLIP_BITS-1:0]        out_flip_total,
  input logic                                 out_bad_index
);
  import tff_pkg::*;

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value) &&
      $stable(out_flip_total) && $stable(out_bad_index))
    else $error("stalled result changed");

  // bad index always returns zero data
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_read_value == '0)
    else $error("bad index with nonzero read value");

  // one transaction in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after acceptance");

  // a busy block cannot finish while the output is blocked
  a_blocked_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_valid && !out_ready |=> !in_ready)
    else $error("ready while output blocked");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind ternary_register_file_flip_count_top tff_checker u_tff_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_value (out_read_value),
  .out_flip_total (out_flip_total),
  .out_bad_index  (out_bad_index)
);
